// File: rtl/udfb_pkg.sv
// udfb_pkg: shared types and constants for the function bounds unit
// used by udfb_front, udfb_queue, udfb_back and the top level
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package udfb_pkg;

  // address and field widths
  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SHIFT_W   = 7;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 136;

  // leb128 decoding constants
  localparam logic [BYTE_W-1:0]  LEB_PAYLOAD_MASK = 8'h7F;
  localparam logic [BYTE_W-1:0]  LEB_CONT_MASK    = 8'h80;
  localparam logic [SHIFT_W-1:0] LEB_STEP         = 7'd7;
  localparam logic [SHIFT_W-1:0] LEB_SHIFT_LIMIT  = 7'd64;

  // default depth of the event queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // configuration register indexes
  localparam logic CFG_IMAGE_BASE    = 1'b0;
  localparam logic CFG_QUERY_ADDRESS = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND   = 2'd0,
    ST_BEFORE  = 2'd1,
    ST_ZERO    = 2'd2,
    ST_EXHAUST = 2'd3
  } status_t;

  // one classified byte, passed from front to back
  typedef struct packed {
    logic              first;     // table start, reload state
    logic              last;      // final byte of the table
    logic              complete;  // a delta ends on this byte
    logic [ADDR_W-1:0] delta;     // assembled delta when complete
  } evt_t;

endpackage

`default_nettype wire

// File: rtl/udfb_front.sv
// udfb_front: byte intake, assembles uleb128 deltas and classifies each byte
// depends on udfb_pkg
`timescale 1ns / 1ps
`default_nettype none

module udfb_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        byte_valid,
  output      logic                        byte_ready,
  input  wire logic [udfb_pkg::BYTE_W-1:0] table_byte,
  input  wire logic                        first_of_table,
  input  wire logic                        last_of_table,
  output      logic                        evt_valid,
  input  wire logic                        evt_ready,
  output      udfb_pkg::evt_t              evt
);

  logic [udfb_pkg::ADDR_W-1:0]  accum_r, accum_nxt;
  logic [udfb_pkg::SHIFT_W-1:0] shift_r, shift_nxt;
  logic [udfb_pkg::ADDR_W-1:0]  cur_accum, merged, payload;
  logic [udfb_pkg::SHIFT_W-1:0] cur_shift;
  logic                         in_range, complete, take;

  assign byte_ready = evt_ready;
  assign evt_valid  = byte_valid;
  assign take       = byte_valid && evt_ready;

  // a table start restarts decoding from an empty delta
  always_comb begin
    cur_accum = first_of_table ? '0 : accum_r;
    cur_shift = first_of_table ? '0 : shift_r;
    in_range  = (cur_shift < udfb_pkg::LEB_SHIFT_LIMIT);
    payload   = udfb_pkg::ADDR_W'(table_byte & udfb_pkg::LEB_PAYLOAD_MASK);
    // payload bits beyond bit 63 fall off the shift
    merged    = in_range ? (cur_accum | (payload << cur_shift[5:0])) : cur_accum;
    complete  = ((table_byte & udfb_pkg::LEB_CONT_MASK) == '0);
  end

  // next decoding state, shift saturates once past the word
  always_comb begin
    if (complete) begin
      accum_nxt = '0;
      shift_nxt = '0;
    end else begin
      accum_nxt = merged;
      shift_nxt = in_range ? (cur_shift + udfb_pkg::LEB_STEP) : cur_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
      shift_r <= '0;
    end else if (take) begin
      accum_r <= accum_nxt;
      shift_r <= shift_nxt;
    end
  end

  // event for the back end
  always_comb begin
    evt.first    = first_of_table;
    evt.last     = last_of_table;
    evt.complete = complete;
    evt.delta    = merged;
  end

endmodule

`default_nettype wire

// File: rtl/udfb_queue.sv
// udfb_queue: short register queue of classified events between front and back
// depends on udfb_pkg
`timescale 1ns / 1ps
`default_nettype none

module udfb_queue #(
  parameter int unsigned DEPTH = udfb_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output      logic           push_ready,
  input  wire udfb_pkg::evt_t push_evt,
  output      logic           pop_valid,
  input  wire logic           pop_ready,
  output      udfb_pkg::evt_t pop_evt
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  udfb_pkg::evt_t     mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_evt    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_evt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/udfb_back.sv
// udfb_back: accumulates function addresses, brackets the query, registers results
// depends on udfb_pkg
`timescale 1ns / 1ps
`default_nettype none

module udfb_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [udfb_pkg::ADDR_W-1:0]   image_base,
  input  wire logic [udfb_pkg::ADDR_W-1:0]   query_address,
  input  wire logic                          evt_valid,
  output      logic                          evt_ready,
  input  wire udfb_pkg::evt_t                evt,
  output      logic                          res_valid,
  input  wire logic                          res_ready,
  output      udfb_pkg::status_t             res_status,
  output      logic [udfb_pkg::ADDR_W-1:0]   res_start,
  output      logic [udfb_pkg::ADDR_W-1:0]   res_end
);

  logic [udfb_pkg::ADDR_W-1:0] addr_r, addr_nxt, best_r, best_nxt;
  logic                        fin_r, fin_nxt;
  logic                        valid_r, valid_nxt;
  udfb_pkg::status_t           status_r, status_nxt;
  logic [udfb_pkg::ADDR_W-1:0] start_r, start_nxt, end_r, end_nxt;
  logic [udfb_pkg::ADDR_W-1:0] base, best_cur, sum;
  logic                        take, active, emit, at_or_below;

  // the output register frees when empty or being taken
  assign evt_ready = !valid_r || res_ready;
  assign take      = evt_valid && evt_ready;

  assign active      = evt.first || !fin_r;
  assign base        = evt.first ? image_base : addr_r;
  assign best_cur    = evt.first ? '0 : best_r;
  assign sum         = base + evt.delta;
  assign at_or_below = (sum <= query_address);

  // classify one event against the running address
  always_comb begin
    addr_nxt   = addr_r;
    best_nxt   = best_r;
    fin_nxt    = fin_r;
    emit       = 1'b0;
    status_nxt = udfb_pkg::ST_FOUND;
    start_nxt  = '0;
    end_nxt    = '0;
    if (active) begin
      addr_nxt = base;
      best_nxt = best_cur;
      if (evt.complete) begin
        if (evt.delta == '0) begin
          emit       = 1'b1;
          status_nxt = udfb_pkg::ST_ZERO;
        end else begin
          addr_nxt = sum;
          if (at_or_below) begin
            best_nxt = sum;
          end else if (best_cur == '0) begin
            emit       = 1'b1;
            status_nxt = udfb_pkg::ST_BEFORE;
          end else begin
            emit       = 1'b1;
            status_nxt = udfb_pkg::ST_FOUND;
            start_nxt  = best_cur;
            end_nxt    = sum;
          end
        end
      end
      // last byte with nothing reported yet
      if (!emit && evt.last) begin
        emit       = 1'b1;
        status_nxt = udfb_pkg::ST_EXHAUST;
      end
      fin_nxt = emit;
    end
  end

  // output valid follows transfers on both sides
  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = emit;
    end else if (res_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r  <= '0;
      best_r  <= '0;
      fin_r   <= 1'b1;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (take) begin
        addr_r <= addr_nxt;
        best_r <= best_nxt;
        fin_r  <= fin_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take && emit) begin
      status_r <= status_nxt;
      start_r  <= start_nxt;
      end_r    <= end_nxt;
    end
  end

  assign res_valid  = valid_r;
  assign res_status = status_r;
  assign res_start  = start_r;
  assign res_end    = end_r;

endmodule

`default_nettype wire

// File: rtl/uleb_delta_function_bounds_unit.sv
// Function bounds unit: takes a table of uleb128 function-start deltas one byte per
// cycle while the event queue has room, and returns, once per table, the pair of
// function starts bracketing the configured query address, or a status saying why
// none was found. Bytes are taken at one per cycle sustained until the queue fills;
// the byte completing a result is written to the event queue, and the registered
// back end (one 64-bit add and compare per byte) takes it from there and registers
// the result for the output. The event queue holds QUEUE_DEPTH bytes, so up to that
// many bytes are still taken while a result waits on the output. Configuration
// writes are taken every cycle and should be made only while no table is in flight.
// depends on udfb_pkg, udfb_front, udfb_queue, udfb_back
`timescale 1ns / 1ps
`default_nettype none

module uleb_delta_function_bounds_unit #(
  parameter int unsigned QUEUE_DEPTH = udfb_pkg::QUEUE_DEPTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // table bytes
  input  wire logic                                 in_tvalid,
  output      logic                                 in_tready,
  input  wire logic [udfb_pkg::IN_TDATA_W-1:0]      in_tdata,  // [7:0] table_byte
  input  wire logic                                 in_tuser,  // [0] first_of_table
  input  wire logic                                 in_tlast,  // last_of_table
  // results
  output      logic                                 out_tvalid,
  input  wire logic                                 out_tready,
  // [1:0] status, [65:2] func_start, [129:66] func_end, [135:130] zero
  output      logic [udfb_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // configuration writes
  input  wire logic                                 cfg_valid,
  output      logic                                 cfg_ready,
  input  wire logic                                 cfg_index,
  input  wire logic [udfb_pkg::ADDR_W-1:0]          cfg_data
);

  logic [udfb_pkg::ADDR_W-1:0] image_base_r, query_address_r;
  logic                        f_valid, f_ready, b_valid, b_ready, res_valid;
  udfb_pkg::evt_t              f_evt, b_evt;
  udfb_pkg::status_t           res_status;
  logic [udfb_pkg::ADDR_W-1:0] res_start, res_end;

  // configuration registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_base_r    <= '0;
      query_address_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        udfb_pkg::CFG_IMAGE_BASE:    image_base_r    <= cfg_data;
        udfb_pkg::CFG_QUERY_ADDRESS: query_address_r <= cfg_data;
        default:                     ;
      endcase
    end
  end

  // front: delta assembly and byte classification
  udfb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .byte_valid     (in_tvalid),
    .byte_ready     (in_tready),
    .table_byte     (in_tdata[udfb_pkg::BYTE_W-1:0]),
    .first_of_table (in_tuser),
    .last_of_table  (in_tlast),
    .evt_valid      (f_valid),
    .evt_ready      (f_ready),
    .evt            (f_evt)
  );

  // event queue decoupling the two halves
  udfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_evt   (f_evt),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_evt    (b_evt)
  );

  // back: address accumulation and query bracketing
  udfb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .image_base    (image_base_r),
    .query_address (query_address_r),
    .evt_valid     (b_valid),
    .evt_ready     (b_ready),
    .evt           (b_evt),
    .res_valid     (res_valid),
    .res_ready     (out_tready),
    .res_status    (res_status),
    .res_start     (res_start),
    .res_end       (res_end)
  );

  // pack the result transfer
  assign out_tvalid = res_valid;
  assign out_tdata  = {6'b0, res_end, res_start, res_status};

endmodule

`default_nettype wire

// File: verif/tb_uleb_delta_function_bounds_unit.sv
// tb_uleb_delta_function_bounds_unit: self-checking bench for the function bounds unit
// drives leb128 delta tables, predicts the bracketing pair per table and checks each result
// depends on udfb_pkg and uleb_delta_function_bounds_unit
`timescale 1ns / 1ps

module tb_uleb_delta_function_bounds_unit;

  // one expected result, same fields as the output transfer
  typedef struct packed {
    udfb_pkg::status_t           status;
    logic [udfb_pkg::ADDR_W-1:0] fn_start;
    logic [udfb_pkg::ADDR_W-1:0] fn_end;
  } bounds_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [udfb_pkg::IN_TDATA_W-1:0]   in_tdata  = '0;
  logic                              in_tuser  = 1'b0;
  logic                              in_tlast  = 1'b0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [udfb_pkg::OUT_TDATA_W-1:0]  out_tdata;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic                              cfg_index = udfb_pkg::CFG_IMAGE_BASE;
  logic [udfb_pkg::ADDR_W-1:0]       cfg_data  = '0;

  uleb_delta_function_bounds_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // predictor copy of registers and decode state
  logic [udfb_pkg::ADDR_W-1:0]  cfg_base   = '0;
  logic [udfb_pkg::ADDR_W-1:0]  cfg_query  = '0;
  logic [udfb_pkg::ADDR_W-1:0]  leb_accum  = '0;
  logic [udfb_pkg::SHIFT_W-1:0] leb_shift  = '0;
  logic [udfb_pkg::ADDR_W-1:0]  run_addr   = '0;
  logic [udfb_pkg::ADDR_W-1:0]  best_addr  = '0;
  bit                           table_done = 1'b1;

  bounds_t pending_bounds[$];
  int      mismatch_count = 0;
  int      bytes_sent     = 0;
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;
  int      delta_span     = 1;

  // advance the predictor by one table byte, returns 1 when a result is due
  function automatic bit decode_table_byte(input logic [udfb_pkg::BYTE_W-1:0] b,
                                           input bit first, input bit last,
                                           output bounds_t r);
    logic [udfb_pkg::ADDR_W-1:0] delta;
    r = '{udfb_pkg::ST_FOUND, '0, '0};
    if (first) begin
      leb_accum  = '0;
      leb_shift  = '0;
      run_addr   = cfg_base;
      best_addr  = '0;
      table_done = 1'b0;
    end else if (table_done) begin
      return 1'b0;
    end
    // payload beyond bit 63 is dropped, shift saturates
    if (leb_shift < udfb_pkg::LEB_SHIFT_LIMIT) begin
      leb_accum = leb_accum |
                  (udfb_pkg::ADDR_W'(b & udfb_pkg::LEB_PAYLOAD_MASK) << leb_shift);
      leb_shift = leb_shift + udfb_pkg::LEB_STEP;
    end
    if ((b & udfb_pkg::LEB_CONT_MASK) == '0) begin
      delta     = leb_accum;
      leb_accum = '0;
      leb_shift = '0;
      if (delta == '0) begin
        r.status   = udfb_pkg::ST_ZERO;
        table_done = 1'b1;
        return 1'b1;
      end
      run_addr = run_addr + delta;
      if (run_addr <= cfg_query) begin
        best_addr = run_addr;
      end else begin
        // a start of zero counts as no start yet
        if (best_addr == '0) begin
          r.status = udfb_pkg::ST_BEFORE;
        end else begin
          r.status   = udfb_pkg::ST_FOUND;
          r.fn_start = best_addr;
          r.fn_end   = run_addr;
        end
        table_done = 1'b1;
        return 1'b1;
      end
    end
    if (last) begin
      r.status   = udfb_pkg::ST_EXHAUST;
      table_done = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // append the leb128 encoding of v, with pad extra continuation bytes
  function automatic void encode_leb(ref logic [udfb_pkg::BYTE_W-1:0] seq[$],
                                     input logic [udfb_pkg::ADDR_W-1:0] v, input int pad);
    logic [udfb_pkg::BYTE_W-1:0] b;
    int  idx;
    bit  done;
    idx  = 0;
    done = 1'b0;
    while (!done) begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      // bytes past shift 64 carry junk payload that must be dropped
      if (idx >= 10) b[6:0] = 7'($urandom);
      idx++;
      if (v != '0) begin
        seq.push_back(b | udfb_pkg::LEB_CONT_MASK);
      end else if (pad > 0) begin
        seq.push_back(b | udfb_pkg::LEB_CONT_MASK);
        pad--;
      end else begin
        seq.push_back(b);
        done = 1'b1;
      end
    end
  endfunction

  // one input transfer with random gaps before it
  task automatic send_byte(input logic [udfb_pkg::BYTE_W-1:0] b, input logic first,
                           input logic last);
    bounds_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= first;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    if (decode_table_byte(b, first, last, r)) pending_bounds.push_back(r);
  endtask

  // stop sending and let every expected result and in-flight byte drain
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (pending_bounds.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // one configuration transfer, valid dropped for a cycle afterwards
  task automatic write_reg(input logic idx, input logic [udfb_pkg::ADDR_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == udfb_pkg::CFG_IMAGE_BASE) cfg_base = v;
    else cfg_query = v;
    @(posedge clk);
  endtask

  // result sink with random backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic flag_mismatch(input string what, input logic [udfb_pkg::ADDR_W-1:0] want,
                               input logic [udfb_pkg::ADDR_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %0s at %0t: expected %h got %h", what, $realtime, want, got);
  endtask

  // compare each result transfer against the oldest expectation
  always @(posedge clk) begin : check_results
    bounds_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bounds.size() == 0) begin
        flag_mismatch("unexpected result", '0, udfb_pkg::ADDR_W'(out_tdata[1:0]));
      end else begin
        want = pending_bounds.pop_front();
        if (out_tdata[1:0] !== want.status)
          flag_mismatch("status", udfb_pkg::ADDR_W'(want.status),
                        udfb_pkg::ADDR_W'(out_tdata[1:0]));
        if (out_tdata[65:2] !== want.fn_start)
          flag_mismatch("func_start", want.fn_start, out_tdata[65:2]);
        if (out_tdata[129:66] !== want.fn_end)
          flag_mismatch("func_end", want.fn_end, out_tdata[129:66]);
        if (out_tdata[135:130] !== '0)
          flag_mismatch("padding", '0, udfb_pkg::ADDR_W'(out_tdata[135:130]));
      end
    end
  end

  // each status reached on purpose, plus restart and oversized deltas
  task automatic test_directed_cases();
    write_reg(udfb_pkg::CFG_IMAGE_BASE, 64'h1000);
    write_reg(udfb_pkg::CFG_QUERY_ADDRESS, 64'h1050);
    // found: starts 0x1010, 0x1050, 0x1055; trailing byte ignored
    send_byte(8'h10, 1'b1, 1'b0);
    send_byte(8'h40, 1'b0, 1'b0);
    send_byte(8'h05, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    // first start already above the query
    send_byte(8'h60, 1'b1, 1'b1);
    // zero delta terminator
    send_byte(8'h00, 1'b1, 1'b0);
    // table runs out below the query
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'h02, 1'b0, 1'b1);
    // last byte leaves a delta open
    send_byte(8'h81, 1'b1, 1'b1);
    // restart while a table is in progress
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'h70, 1'b1, 1'b0);
    // overlong delta: shift saturates and the final payload is dropped
    send_byte(8'h80, 1'b1, 1'b0);
    repeat (9) send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b1);
    wait_results_drained();
  endtask

  // running address wrapping to zero, and register extremes
  task automatic test_wrap_and_extremes();
    write_reg(udfb_pkg::CFG_IMAGE_BASE, 64'hFFFF_FFFF_FFFF_FFF0);
    write_reg(udfb_pkg::CFG_QUERY_ADDRESS, 64'h20);
    send_byte(8'h10, 1'b1, 1'b0);
    send_byte(8'h30, 1'b0, 1'b0);
    wait_results_drained();
    write_reg(udfb_pkg::CFG_IMAGE_BASE, '1);
    write_reg(udfb_pkg::CFG_QUERY_ADDRESS, '1);
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'h05, 1'b0, 1'b1);
    wait_results_drained();
    write_reg(udfb_pkg::CFG_IMAGE_BASE, '0);
    write_reg(udfb_pkg::CFG_QUERY_ADDRESS, '0);
    send_byte(8'h03, 1'b1, 1'b1);
    wait_results_drained();
  endtask

  // one table, mostly well formed, sometimes broken or followed by noise
  task automatic send_random_table();
    logic [udfb_pkg::BYTE_W-1:0] seq[$];
    logic [udfb_pkg::ADDR_W-1:0] d;
    int n_deltas;
    int kind;
    int shape;
    n_deltas = $urandom_range(1, 6);
    for (int i = 0; i < n_deltas; i++) begin
      kind = $urandom_range(99);
      if (kind < 70) d = udfb_pkg::ADDR_W'($urandom_range(1, delta_span));
      else if (kind < 78) d = {$urandom, $urandom};
      else if (kind < 84) d = '0;
      else d = udfb_pkg::ADDR_W'($urandom_range(1, 127));
      encode_leb(seq, d, (kind >= 90) ? $urandom_range(1, 12) : 0);
    end
    shape = $urandom_range(99);
    // last delta left incomplete
    if (shape < 8) seq[seq.size()-1] = seq[seq.size()-1] | udfb_pkg::LEB_CONT_MASK;
    foreach (seq[i])
      send_byte(seq[i], i == 0, (i == seq.size() - 1) && !(shape >= 8 && shape < 12));
    // noise, possibly restarting or extending an open table
    if (shape >= 88) begin
      repeat ($urandom_range(1, 3))
        send_byte(8'($urandom), $urandom_range(9) == 0, 1'($urandom));
    end
  endtask

  // several register settings, each drained before the next write
  task automatic test_random_tables(input int tx_idle, input int rx_stall, input int n_bytes);
    logic [udfb_pkg::ADDR_W-1:0] base;
    int stop_at;
    send_idle_pct  = tx_idle;
    recv_stall_pct = rx_stall;
    for (int k = 0; k < 4; k++) begin
      wait_results_drained();
      delta_span = $urandom_range(1, 600);
      case ($urandom_range(3))
        0:       base = '0;
        1:       base = '1;
        default: base = {$urandom, $urandom};
      endcase
      write_reg(udfb_pkg::CFG_IMAGE_BASE, base);
      write_reg(udfb_pkg::CFG_QUERY_ADDRESS,
                base + udfb_pkg::ADDR_W'($urandom_range(0, 3 * delta_span)));
      stop_at = bytes_sent + n_bytes / 4;
      while (bytes_sent < stop_at) send_random_table();
    end
    wait_results_drained();
  endtask

  // test sequence
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_wrap_and_extremes();
    test_random_tables(0, 0, 380);
    test_random_tables(85, 0, 380);
    test_random_tables(0, 85, 380);
    test_random_tables(20, 20, 380);
    wait_results_drained();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
